### src/mhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int COUNT_OUT_W  = 8;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 128;

  typedef enum logic {
    KIND_INSERT  = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic                    insert;
    logic                    extract;
    logic signed [KEY_W-1:0] key;
  } op_t;

endpackage : mhpq_pkg
`default_nettype wire

### src/mhpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted key row: compares against the broadcast key and
// takes its value from itself, its left neighbor, the key or its right neighbor.
// ----------------------------------------------------------------------------
module mhpq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 8
) (
  input  wire                              clk,
  input  mhpq_pkg::op_t                    op,
  input  wire [CNT_W-1:0]                  count,
  input  wire                              prev_lt,
  input  wire signed [mhpq_pkg::KEY_W-1:0] prev_data,
  input  wire signed [mhpq_pkg::KEY_W-1:0] next_data,
  output logic                             lt,
  output logic signed [mhpq_pkg::KEY_W-1:0] data
);

  logic occupied;

  assign occupied = (count > CNT_W'(INDEX));
  // An empty slot counts as larger than any key
  assign lt = !occupied || (op.key < data);

  always_ff @(posedge clk) begin
    if (op.insert && lt) begin
      // shift right: the first slot past the key takes the key itself
      data <= prev_lt ? prev_data : op.key;
    end else if (op.extract) begin
      data <= next_data;
    end
  end

endmodule : mhpq_cell
`default_nettype wire

### src/min_heap_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Bounded priority queue of signed keys with insert and extract-minimum.
// ----------------------------------------------------------------------------
// The keys sit in a row of CAPACITY cells kept in ascending order; every
// cell compares itself to the broadcast key and the row shifts as one, so
// the block accepts one beat per cycle while the result register is empty
// or being read, set by the single compare-and-shift step of the cell row.
// Each beat yields one result beat in the next cycle, held in an output
// register while the next beat is taken. An insert into a full queue is
// dropped with status full; an extract from an empty queue reports status
// empty. count_out is the entry count after the operation, modulo 256.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] key_in
  input  wire         s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata    // [31:0] min_out, [33:32] status, [41:34] count_out
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KW    = mhpq_pkg::KEY_W;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     out_valid;
  logic signed [KW-1:0]     out_min;
  mhpq_pkg::status_t        out_status;
  logic [7:0]               out_count;

  logic                     accept;
  logic                     full;
  logic                     empty;
  mhpq_pkg::op_t            op;
  mhpq_pkg::status_t        status_next;
  logic signed [KW-1:0]     min_next;
  logic [CNT_W+7:0]         count_wide;

  logic signed [KW-1:0]     cell_data [CAPACITY];
  logic                     cell_lt   [CAPACITY];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  always_comb begin
    op          = '0;
    op.key      = s_tdata;
    status_next = mhpq_pkg::STATUS_OK;
    min_next    = '0;
    count_next  = count;
    unique case (mhpq_pkg::kind_t'(s_tuser))
      mhpq_pkg::KIND_INSERT: begin
        if (full) begin
          status_next = mhpq_pkg::STATUS_FULL;
        end else begin
          op.insert  = accept;
          count_next = count + CNT_W'(1);
        end
      end
      mhpq_pkg::KIND_EXTRACT: begin
        if (empty) begin
          status_next = mhpq_pkg::STATUS_EMPTY;
        end else begin
          op.extract = accept;
          min_next   = cell_data[0];
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = mhpq_pkg::STATUS_OK;
      end
    endcase
  end

  assign count_wide = {8'd0, count_next};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                 prev_lt;
      logic signed [KW-1:0] prev_data;
      logic signed [KW-1:0] next_data;
      if (gi == 0) begin : g_first
        assign prev_lt   = 1'b0;
        assign prev_data = '0;
      end else begin : g_mid
        assign prev_lt   = cell_lt[gi-1];
        assign prev_data = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_data = '0;
      end else begin : g_body
        assign next_data = cell_data[gi+1];
      end
      mhpq_cell #(
        .INDEX (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk       (clk),
        .op        (op),
        .count     (count),
        .prev_lt   (prev_lt),
        .prev_data (prev_data),
        .next_data (next_data),
        .lt        (cell_lt[gi]),
        .data      (cell_data[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_min    <= min_next;
      out_status <= status_next;
      out_count  <= count_wide[7:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_count, out_status, out_min};

endmodule : min_heap_priority_queue
`default_nettype wire

### src/mhpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [31:0] s_tdata,
  input wire        s_tuser,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // every accepted beat shows a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat gave no result");

  // an error or an insert reports a zero minimum
  a_zero_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] != mhpq_pkg::STATUS_OK ||
                 $past(s_tuser) == mhpq_pkg::KIND_INSERT)
      && $past(s_tvalid && s_tready) |-> m_tdata[31:0] == 32'd0)
    else $error("nonzero minimum outside a good extract");

  // an empty extract leaves nothing behind
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == mhpq_pkg::STATUS_EMPTY |-> m_tdata[41:34] == 8'd0)
    else $error("empty status with nonzero count");

endmodule : mhpq_checker

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### bench/min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb
// Self-checking bench for the min-heap priority queue: a queued driver feeds
// insert and extract beats, a scoreboard heap predicts every result beat and
// the monitor compares min_out, status and count_out field by field.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_tb;

  localparam int CAPACITY   = mhpq_pkg::CAPACITY_DEF;
  localparam int NUM_OPS    = 900;
  localparam int PHASE_LEN  = 75;
  localparam int DRAIN_WAIT = 20;

  typedef struct {
    mhpq_pkg::kind_t                   kind;
    logic signed [mhpq_pkg::KEY_W-1:0] key;
    int                                send_idle;
    int                                recv_stall;
  } heap_op_t;

  typedef struct {
    logic signed [mhpq_pkg::KEY_W-1:0] min_key;
    mhpq_pkg::status_t                 status;
    logic [mhpq_pkg::COUNT_OUT_W-1:0]  count;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key_in
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [31:0] min_out, [33:32] status, [41:34] count_out

  heap_op_t     pending_ops[$];
  heap_result_t expected_results[$];
  heap_op_t     op_in_flight;
  int           recv_stall = 0;

  // scoreboard heap
  logic signed [mhpq_pkg::KEY_W-1:0] heap_keys[CAPACITY];
  int unsigned                       heap_size = 0;

  int error_count = 0;
  int insert_cnt = 0, extract_cnt = 0, full_cnt = 0, empty_cnt = 0, peak_fill = 0;

  always #4 clk = ~clk;

  min_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [mhpq_pkg::KEY_W-1:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Apply one operation to the scoreboard heap and return the result beat
  function automatic heap_result_t heap_apply(heap_op_t op);
    heap_result_t r;
    int unsigned  pos, left, right, pick;
    r.min_key = '0;
    r.status  = mhpq_pkg::STATUS_OK;
    if (op.kind == mhpq_pkg::KIND_INSERT) begin
      insert_cnt++;
      if (heap_size >= CAPACITY) begin
        r.status = mhpq_pkg::STATUS_FULL;
        full_cnt++;
      end else begin
        pos = heap_size;
        heap_keys[pos] = op.key;
        heap_size++;
        // sift up; stop at an equal parent
        while (pos > 0 && heap_keys[pos] < heap_keys[(pos - 1) / 2]) begin
          swap_keys(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
      end
    end else begin
      extract_cnt++;
      if (heap_size == 0) begin
        r.status = mhpq_pkg::STATUS_EMPTY;
        empty_cnt++;
      end else begin
        r.min_key = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        // sift down toward the smaller child, left on a tie
        while (2 * pos + 1 < heap_size) begin
          left  = 2 * pos + 1;
          right = left + 1;
          pick  = left;
          if (right < heap_size && heap_keys[right] < heap_keys[left]) pick = right;
          if (!(heap_keys[pick] < heap_keys[pos])) break;
          swap_keys(pos, pick);
          pos = pick;
        end
      end
    end
    if (heap_size > peak_fill) peak_fill = heap_size;
    r.count = heap_size[mhpq_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Driver: predict on each accepted beat, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) expected_results.push_back(heap_apply(op_in_flight));
      if (pending_ops.size() > 0 &&
          $urandom_range(99) >= pending_ops[0].send_idle) begin
        op_in_flight = pending_ops.pop_front();
        recv_stall = op_in_flight.recv_stall;
        s_tvalid <= 1'b1;
        s_tdata  <= op_in_flight.key;
        s_tuser  <= op_in_flight.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %h", m_tdata);
          error_count++;
        end else begin
          heap_result_t want;
          want = expected_results.pop_front();
          if ($signed(m_tdata[31:0]) !== want.min_key) begin
            $error("min_out: expected %0d, got %0d", want.min_key, $signed(m_tdata[31:0]));
            error_count++;
          end
          if (m_tdata[33:32] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[33:32]);
            error_count++;
          end
          if (m_tdata[41:34] !== want.count) begin
            $error("count_out: expected %0d, got %0d", want.count, m_tdata[41:34]);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Track fill while building the stimulus so sweeps hit full and empty
  int gen_fill = 0;

  function automatic void queue_op(mhpq_pkg::kind_t kind,
                                   logic signed [mhpq_pkg::KEY_W-1:0] key);
    heap_op_t op;
    op.kind       = kind;
    op.key        = key;
    op.send_idle  = 0;
    op.recv_stall = 0;
    pending_ops.push_back(op);
    if (kind == mhpq_pkg::KIND_INSERT && gen_fill < CAPACITY) gen_fill++;
    if (kind == mhpq_pkg::KIND_EXTRACT && gen_fill > 0) gen_fill--;
  endfunction

  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: case ($urandom_range(3))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 32'sh0;
           default: return -32'sd1;
         endcase
      1, 2, 3: return $signed($urandom_range(15)) - 8;  // dense, many duplicates
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sweep, wait_cycles, p_ins;

    // empty extracts, extremes and duplicates, then drain past empty
    queue_op(mhpq_pkg::KIND_EXTRACT, 32'sh0);
    queue_op(mhpq_pkg::KIND_EXTRACT, 32'sh5a5a5a5a);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sh7fffffff);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sh80000000);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sh0);
    queue_op(mhpq_pkg::KIND_INSERT, -32'sd1);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd1);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sh80000000);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd5);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd5);
    repeat (9) queue_op(mhpq_pkg::KIND_EXTRACT, 32'sh0);
    // equal children under the root at the extract that follows
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd0);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd4);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd4);
    queue_op(mhpq_pkg::KIND_INSERT, 32'sd9);
    queue_op(mhpq_pkg::KIND_EXTRACT, 32'sh0);

    sweep = 0;
    while (pending_ops.size() < NUM_OPS) begin
      case (sweep < 2 ? sweep : $urandom_range(3))
        0: begin
          while (gen_fill < CAPACITY) queue_op(mhpq_pkg::KIND_INSERT, pick_key());
          repeat (3) queue_op(mhpq_pkg::KIND_INSERT, pick_key());
        end
        1: begin
          while (gen_fill > 0) queue_op(mhpq_pkg::KIND_EXTRACT, $urandom);
          repeat (2) queue_op(mhpq_pkg::KIND_EXTRACT, $urandom);
        end
        default: begin
          p_ins = 25 * $urandom_range(1, 3);
          repeat (50)
            queue_op(($urandom_range(99) < p_ins) ? mhpq_pkg::KIND_INSERT
                                                  : mhpq_pkg::KIND_EXTRACT,
                     ($urandom_range(99) < p_ins) ? pick_key() : $urandom);
        end
      endcase
      sweep++;
    end

    // rotate through the flow-control phases every few dozen beats
    foreach (pending_ops[i]) begin
      case ((i / PHASE_LEN) % 4)
        0: begin pending_ops[i].send_idle = 0;  pending_ops[i].recv_stall = 0;  end
        1: begin pending_ops[i].send_idle = 75; pending_ops[i].recv_stall = 0;  end
        2: begin pending_ops[i].send_idle = 0;  pending_ops[i].recv_stall = 75; end
        default: begin
          pending_ops[i].send_idle = 28; pending_ops[i].recv_stall = 28;
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_ops.size() > 0 || s_tvalid);
    wait_cycles = 0;
    while (expected_results.size() > 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (expected_results.size() > 0) begin
      $error("%0d result beats never arrived", expected_results.size());
      error_count++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d inserts (%0d dropped as full) and %0d extracts (%0d on empty),",
             insert_cnt, full_cnt, extract_cnt, empty_cnt);
    $display("peak fill %0d of %0d, across four flow-control phases.", peak_fill, CAPACITY);
    if (error_count == 0) begin
      $display("min_heap_priority_queue_tb passed");
    end else begin
      $display("min_heap_priority_queue_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("min_heap_priority_queue_tb failed");
    $finish;
  end

endmodule
